### rtl/loop_branch_predictor_assert.svh
// Assertion macros for the loop branch predictor
`ifndef LOOP_BRANCH_PREDICTOR_ASSERT_SVH
`define LOOP_BRANCH_PREDICTOR_ASSERT_SVH

// Same-cycle implication, checked on i_clk outside reset
`define LBP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("loop_branch_predictor: assertion failed");

// Next-cycle implication, checked on i_clk outside reset
`define LBP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("loop_branch_predictor: assertion failed");

`endif

### rtl/lbp_pkg.sv
// Package: sizes, types and codes of the loop branch predictor
package lbp_pkg;

    localparam int INDEX_BITS  = 4;
    localparam int TAG_BITS    = 10;
    localparam int BI_W        = 32;
    localparam int COUNT_W     = 10;
    localparam int COUNT_MAX   = 1023;
    localparam int CONF_MAX    = 7;
    localparam int AGE_MAX     = 7;
    localparam int CONF_W      = $clog2(CONF_MAX + 1);
    localparam int AGE_W       = $clog2(AGE_MAX + 1);
    localparam int NUM_ENTRIES = 1 << INDEX_BITS;

    typedef logic [INDEX_BITS-1:0] t_idx;
    typedef logic [TAG_BITS-1:0]   t_tag;
    typedef logic [COUNT_W-1:0]    t_count;
    typedef logic [CONF_W-1:0]     t_conf;
    typedef logic [AGE_W-1:0]      t_age;
    typedef logic [BI_W-1:0]       t_bi;

    typedef enum logic {
        ACT_PREDICT = 1'b0,
        ACT_UPDATE  = 1'b1
    } t_action;

    typedef struct packed {
        t_tag   tag;
        t_count cur;
        t_count prev;
        t_conf  conf;
        t_age   age;
    } t_entry;

endpackage

### rtl/lbp_ifs.sv
// Channel interfaces of the loop branch predictor: input items and results
interface lbp_in_if;
    logic                      valid;
    logic                      ready;
    logic                      action;
    logic [lbp_pkg::BI_W-1:0]  branch_index;
    logic                      mispredict;
    logic [lbp_pkg::COUNT_W-1:0] prior_count;

    modport source (output valid, action, branch_index, mispredict, prior_count,
                    input ready);
    modport sink   (input valid, action, branch_index, mispredict, prior_count,
                    output ready);
endinterface

interface lbp_out_if;
    logic                        valid;
    logic                        ready;
    logic                        invert;
    logic [lbp_pkg::COUNT_W-1:0] observed_count;

    modport source (output valid, invert, observed_count, input ready);
    modport sink   (input valid, invert, observed_count, output ready);
endinterface

### rtl/loop_branch_predictor.sv
// Loop branch predictor top level: input register, table read-modify-write, result register
// Takes one item (predict or update) per cycle while results are taken, and returns one
// result per item through the input register and then the result register. The rate is
// set by the single compute stage, which reads the 16-entry flip-flop table at the
// item's index and writes the new entry back at the same clock edge, so back-to-back items
// to the same entry see each other's updates. Reset clears the table. A stalled result
// blocks the input only while both registers are full.
`include "loop_branch_predictor_assert.svh"

module loop_branch_predictor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lbp_in_if.sink     i_in,
    lbp_out_if.source  o_out
);
    import lbp_pkg::*;

    logic   r_valid;
    logic   r_action;
    t_bi    r_bi;
    logic   r_misp;
    t_count r_prior;

    t_entry r_tab [NUM_ENTRIES];

    logic   r_out_valid;
    logic   r_out_inv;
    t_count r_out_cnt;

    t_idx   w_idx;
    t_tag   w_tag;
    t_entry w_ent;
    logic   w_hit;
    logic   w_cmatch;
    logic   w_end;
    logic   w_adv;
    t_entry n_ent;
    logic   n_inv;
    t_count n_cnt;

    assign w_idx    = r_bi[INDEX_BITS-1:0];
    assign w_tag    = r_bi[INDEX_BITS +: TAG_BITS];
    assign w_ent    = r_tab[w_idx];
    assign w_hit    = (w_ent.tag == w_tag);
    assign w_cmatch = (r_prior == w_ent.prev);
    assign w_end    = (t_action'(r_action) == ACT_PREDICT) && w_hit
                      && (w_ent.cur == w_ent.prev) && (w_ent.conf == CONF_W'(CONF_MAX));
    assign w_adv    = r_valid && (!r_out_valid || o_out.ready);

    assign i_in.ready           = !r_valid || w_adv;
    assign o_out.valid          = r_out_valid;
    assign o_out.invert         = r_out_inv;
    assign o_out.observed_count = r_out_cnt;

    always_comb begin
        n_ent = w_ent;
        n_inv = 1'b0;
        n_cnt = '0;
        if (t_action'(r_action) == ACT_PREDICT) begin
            n_cnt = w_ent.cur;
            n_inv = w_end;
            if (w_end) begin
                n_ent.cur = '0;
                n_ent.age = AGE_W'(AGE_MAX);
            end else if (w_hit) begin
                n_ent.cur = (w_ent.cur >= COUNT_W'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                               : w_ent.cur + 1'b1;
                n_ent.age = (w_ent.age >= AGE_W'(AGE_MAX)) ? AGE_W'(AGE_MAX)
                                                           : w_ent.age + 1'b1;
            end
        end else if (r_misp) begin
            if (w_ent.conf == CONF_W'(CONF_MAX)) begin
                if (w_hit) begin
                    n_ent.cur  = '0;
                    n_ent.conf = '0;
                end
            end else if (w_ent.conf != '0) begin
                if (w_hit && w_cmatch) begin
                    n_ent.conf = w_ent.conf + 1'b1;
                    n_ent.cur  = '0;
                end else if (w_hit) begin
                    n_ent.conf = '0;
                    n_ent.cur  = '0;
                    n_ent.prev = r_prior;
                end else if (w_ent.age == '0) begin
                    n_ent.tag  = w_tag;
                    n_ent.conf = CONF_W'(1);
                    n_ent.cur  = '0;
                    n_ent.prev = r_prior;
                end else begin
                    n_ent.age = w_ent.age - 1'b1;
                end
            end else begin
                n_ent.age = AGE_W'(AGE_MAX);
                n_ent.cur = '0;
                if (w_hit && w_cmatch) begin
                    n_ent.conf = CONF_W'(1);
                end else if (w_hit) begin
                    n_ent.prev = r_prior;
                end else begin
                    n_ent.tag  = w_tag;
                    n_ent.conf = CONF_W'(1);
                    n_ent.prev = r_prior;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                r_tab[i] <= '0;
            end
        end else begin
            if (i_in.ready) begin
                r_valid <= i_in.valid;
            end
            if (w_adv) begin
                r_tab[w_idx] <= n_ent;
                r_out_valid  <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_action <= i_in.action;
            r_bi     <= i_in.branch_index;
            r_misp   <= i_in.mispredict;
            r_prior  <= i_in.prior_count;
        end
        if (w_adv) begin
            r_out_inv <= n_inv;
            r_out_cnt <= n_cnt;
        end
    end

    `LBP_ASSERT_SAME(a_ready_when_out_free, !r_out_valid, i_in.ready)
    `LBP_ASSERT_NEXT(a_end_restarts_count, w_adv && w_end, r_tab[$past(w_idx)].cur == '0)
    `LBP_ASSERT_NEXT(a_update_no_misp_keeps_entry,
        w_adv && (t_action'(r_action) == ACT_UPDATE) && !r_misp,
        r_tab[$past(w_idx)] == $past(w_ent))
    `LBP_ASSERT_NEXT(a_update_result_zero,
        w_adv && (t_action'(r_action) == ACT_UPDATE),
        !r_out_inv && (r_out_cnt == '0))

endmodule

### tb/testbench.sv
// Testbench for the loop branch predictor: table-tracking checker, directed and loop-driven traffic
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lbp_pkg::*;

    typedef struct packed {
        logic   invert;
        t_count count;
    } t_outcome;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lbp_in_if  in_if ();
    lbp_out_if out_if ();

    loop_branch_predictor i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_entry   loop_tab [NUM_ENTRIES];
    t_outcome lookup_outcomes [$];
    t_outcome want;
    bit       calm = 1'b0;
    int       fails = 0;
    int       items_sent = 0;
    int       results_seen = 0;
    int       loop_ends_seen = 0;
    t_bi      loop_pc [8];
    int       loop_trip [8];

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic t_outcome loop_table_step(t_action act, t_bi bi, logic misp,
                                                 t_count prior);
        t_idx     ix;
        t_tag     tg;
        t_entry   e;
        logic     hit;
        logic     at_end;
        logic     same;
        t_outcome r;
        ix = bi[INDEX_BITS-1:0];
        tg = bi[INDEX_BITS +: TAG_BITS];
        e = loop_tab[ix];
        hit = (e.tag == tg);
        same = (prior == e.prev);
        r = '0;
        if (act == ACT_PREDICT) begin
            r.count = e.cur;
            if (hit) begin
                at_end = (e.cur == e.prev) && (e.conf == t_conf'(CONF_MAX));
                r.invert = at_end;
                if (at_end) begin
                    e.cur = '0;
                    e.age = t_age'(AGE_MAX);
                end else begin
                    if (e.cur != t_count'(COUNT_MAX)) e.cur = e.cur + 1'b1;
                    if (e.age != t_age'(AGE_MAX)) e.age = e.age + 1'b1;
                end
            end
        end else if (misp) begin
            if (e.conf == t_conf'(CONF_MAX)) begin
                if (hit) begin
                    e.cur = '0;
                    e.conf = '0;
                end
            end else if (e.conf != '0) begin
                if (hit && same) begin
                    e.conf = e.conf + 1'b1;
                    e.cur = '0;
                end else if (hit) begin
                    e.conf = '0;
                    e.cur = '0;
                    e.prev = prior;
                end else if (e.age == '0) begin
                    e.tag = tg;
                    e.conf = t_conf'(1);
                    e.cur = '0;
                    e.prev = prior;
                end else begin
                    e.age = e.age - 1'b1;
                end
            end else begin
                if (hit && same) begin
                    e.conf = t_conf'(1);
                    e.age = t_age'(AGE_MAX);
                    e.cur = '0;
                end else if (hit) begin
                    e.prev = prior;
                    e.age = t_age'(AGE_MAX);
                    e.cur = '0;
                end else begin
                    e.tag = tg;
                    e.conf = t_conf'(1);
                    e.age = t_age'(AGE_MAX);
                    e.cur = '0;
                    e.prev = prior;
                end
            end
        end
        loop_tab[ix] = e;
        return r;
    endfunction

    initial begin
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            results_seen++;
            if (out_if.invert) loop_ends_seen++;
            if (lookup_outcomes.size() == 0) begin
                $error("result with nothing pending: invert %0d, observed_count %0d",
                       out_if.invert, out_if.observed_count);
                fails++;
            end else begin
                want = lookup_outcomes.pop_front();
                if (out_if.invert !== want.invert) begin
                    $error("invert: expected %0d, got %0d", want.invert, out_if.invert);
                    fails++;
                end
                if (out_if.observed_count !== want.count) begin
                    $error("observed_count: expected %0d, got %0d", want.count,
                           out_if.observed_count);
                    fails++;
                end
            end
        end
    end

    task automatic send_item(input t_action act, input t_bi bi, input logic misp,
                             input t_count prior, output t_outcome r);
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.action       <= act;
        in_if.branch_index <= bi;
        in_if.mispredict   <= misp;
        in_if.prior_count  <= prior;
        do @(posedge i_clk); while (!in_if.ready);
        r = loop_table_step(act, bi, misp, prior);
        lookup_outcomes.push_back(r);
        items_sent++;
    endtask

    task automatic wait_drained();
        if (lookup_outcomes.size() != 0) begin
            in_if.valid <= 1'b0;
            while (lookup_outcomes.size() != 0) @(posedge i_clk);
        end
    endtask

    task automatic test_directed();
        t_outcome r;
        send_item(ACT_PREDICT, 32'h0000_0000, 1'b1, 10'h3FF, r);
        send_item(ACT_PREDICT, 32'hFFFF_FFFF, 1'b0, 10'h000, r);
        send_item(ACT_UPDATE, 32'hFFFF_FFFF, 1'b0, 10'h3FF, r);
        send_item(ACT_UPDATE, 32'hFFFF_FFFF, 1'b1, 10'h3FF, r);
        // drain the age of entry 15 with another tag, then take it over
        repeat (8) send_item(ACT_UPDATE, 32'h0000_000F, 1'b1, 10'h000, r);
        send_item(ACT_UPDATE, 32'h0000_0000, 1'b1, 10'd5, r);
        send_item(ACT_UPDATE, 32'h0000_0000, 1'b1, 10'd5, r);
        send_item(ACT_UPDATE, 32'h0000_0000, 1'b1, 10'd9, r);
        send_item(ACT_UPDATE, 32'h0000_0000, 1'b1, 10'd9, r);
        send_item(ACT_UPDATE, 32'h0000_0000, 1'b1, 10'd9, r);
        send_item(ACT_PREDICT, 32'h0000_3FF0, 1'b0, 10'h155, r);
        send_item(ACT_UPDATE, 32'h0000_3FF0, 1'b1, 10'h000, r);
        send_item(ACT_PREDICT, 32'h0000_0000, 1'b0, 10'h2AA, r);
        send_item(ACT_UPDATE, 32'hAAAA_5555, 1'b0, 10'h155, r);
    endtask

    task automatic test_count_limit();
        t_outcome r;
        t_bi      bi;
        wait_drained();
        bi = ($urandom & 32'hFFFF_C000) | 32'd7;
        repeat (COUNT_MAX + 8) send_item(ACT_PREDICT, bi, 1'($urandom), t_count'($urandom), r);
        send_item(ACT_UPDATE, bi, 1'b1, r.count, r);
        send_item(ACT_UPDATE, bi, 1'b1, t_count'(COUNT_MAX), r);
        send_item(ACT_PREDICT, bi, 1'b0, '0, r);
    endtask

    task automatic run_loop(input t_bi bi, input int trip_n);
        t_outcome p;
        t_outcome u;
        logic     misp;
        t_count   seen;
        for (int k = 0; k <= trip_n; k++) begin
            send_item(ACT_PREDICT, bi, 1'($urandom), t_count'($urandom), p);
            misp = (p.invert != (k == trip_n));
            seen = p.count;
            if ($urandom_range(0, 24) == 0) misp = ~misp;
            if ($urandom_range(0, 24) == 0) seen = t_count'($urandom);
            send_item(ACT_UPDATE, bi, misp, seen, u);
        end
    endtask

    task automatic pick_loop(input int j);
        t_bi hi;
        hi = $urandom & 32'hFFFF_C000;
        loop_pc[j] = hi | t_bi'((j < 5 ? j * 3 : (j - 5) * 3) % NUM_ENTRIES);
        if ($urandom_range(0, 4) != 0) loop_pc[j] |= t_bi'($urandom_range(0, 1023)) << INDEX_BITS;
        loop_trip[j] = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                    : $urandom_range(0, 12);
    endtask

    task automatic test_loops();
        t_outcome r;
        int       sel;
        int       j;
        for (int i = 0; i < 8; i++) pick_loop(i);
        while (items_sent < 1450) begin
            if (items_sent > 1300) calm = 1'b1;
            sel = $urandom_range(0, 19);
            j = $urandom_range(0, 7);
            if (sel < 14) begin
                repeat ($urandom_range(1, 4)) run_loop(loop_pc[j], loop_trip[j]);
            end else if (sel < 18) begin
                repeat ($urandom_range(1, 6)) begin
                    if ($urandom_range(0, 1) == 0) begin
                        send_item(t_action'($urandom_range(0, 1)), $urandom, 1'($urandom),
                                  t_count'($urandom), r);
                    end else begin
                        send_item(t_action'($urandom_range(0, 1)),
                                  (loop_pc[j] & 32'h0000_3FFF) | ($urandom & 32'hFFFF_C000),
                                  1'($urandom), t_count'($urandom), r);
                    end
                end
            end else begin
                wait_drained();
                if ($urandom_range(0, 2) == 0) pick_loop(j);
            end
        end
    endtask

    task automatic finish_run();
        wait_drained();
        repeat (4) @(posedge i_clk);
        $display("Sent %0d items (directed, count saturation, looping branches, noise);",
                 items_sent);
        $display("checked %0d results, %0d of them loop-end inversions.", results_seen,
                 loop_ends_seen);
        if (fails == 0 && lookup_outcomes.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        in_if.valid        <= 1'b0;
        in_if.action       <= ACT_PREDICT;
        in_if.branch_index <= '0;
        in_if.mispredict   <= 1'b0;
        in_if.prior_count  <= '0;
        for (int i = 0; i < NUM_ENTRIES; i++) loop_tab[i] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_count_limit();
        test_loops();
        finish_run();
    end

endmodule

### filelist.f
+incdir+rtl
rtl/lbp_pkg.sv
rtl/lbp_ifs.sv
rtl/loop_branch_predictor.sv
tb/testbench.sv
